FILE: design/bcct_pkg.sv
// ----------------------------------------------------------------------------
// bcct_pkg
// Shared constants for the box/circle collision test and its checker.
// ----------------------------------------------------------------------------
package bcct_pkg;

  // default coordinate width, two's complement
  localparam int unsigned COORD_BITS_DEF = 16;

endpackage

FILE: design/box_circle_collision_test.sv
// ----------------------------------------------------------------------------
// box_circle_collision_test
// An accepted item moves through the stage registers in order; hit_o and done_o
// come from the last stage and are registered together.
// Throughput: one item per cycle; busy_o stays low, the receiver cannot stall.
// Five register stages: compare, abs, square, sum, decide.
// Reset clears the stage valid bits only; items in flight at reset are dropped.
// Each pair is an axis-aligned box or a circle per shape, exact integer math.
// ----------------------------------------------------------------------------
module box_circle_collision_test #(
  parameter int unsigned COORD_BITS = bcct_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         a_is_circle_i,
  input  logic signed [COORD_BITS-1:0] a_v0_i,
  input  logic signed [COORD_BITS-1:0] a_v1_i,
  input  logic signed [COORD_BITS-1:0] a_v2_i,
  input  logic signed [COORD_BITS-1:0] a_v3_i,
  input  logic                         b_is_circle_i,
  input  logic signed [COORD_BITS-1:0] b_v0_i,
  input  logic signed [COORD_BITS-1:0] b_v1_i,
  input  logic signed [COORD_BITS-1:0] b_v2_i,
  input  logic signed [COORD_BITS-1:0] b_v3_i,
  output logic                         done_o,
  output logic                         hit_o
);

  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned DW   = CW + 1;
  localparam int unsigned SQW  = 2 * DW;
  localparam int unsigned SUMW = SQW + 1;

  typedef enum logic [1:0] {
    KIND_BOX_BOX,
    KIND_BOX_CIRC,
    KIND_CIRC_CIRC
  } pair_kind_e;

  // ---------------------------------------------------------------- stage 1
  logic                 v1_q;
  pair_kind_e           kind1_d, kind1_q;
  logic signed [DW-1:0] dx0_d, dx1_d, dy0_d, dy1_d;
  logic signed [DW-1:0] dx0_q, dx1_q, dy0_q, dy1_q;
  logic [DW-1:0]        rad_d, rad_q;
  logic                 early1_d, early1_q;
  logic                 bbox1_d, bbox1_q;

  always_comb begin
    logic                 box_is_b;
    logic signed [CW-1:0] bx0, bx1, by0, by1, ccx, ccy, crad;
    logic [CW-1:0]        ra, rb, rc;
    logic signed [DW-1:0] rs, lo_x, hi_x, lo_y, hi_y;
    logic                 bb_hit, inbox, proj_x, proj_y;

    box_is_b = a_is_circle_i;
    bx0  = box_is_b ? b_v0_i : a_v0_i;
    bx1  = box_is_b ? b_v1_i : a_v1_i;
    by0  = box_is_b ? b_v2_i : a_v2_i;
    by1  = box_is_b ? b_v3_i : a_v3_i;
    ccx  = box_is_b ? a_v0_i : b_v0_i;
    ccy  = box_is_b ? a_v1_i : b_v1_i;
    crad = box_is_b ? a_v2_i : b_v2_i;

    // negative radii clamp to zero
    ra = a_v2_i[CW-1] ? '0 : a_v2_i;
    rb = b_v2_i[CW-1] ? '0 : b_v2_i;
    rc = crad[CW-1]   ? '0 : crad;
    rs = $signed({1'b0, rc});

    // bounding box of the circle against the box, strict
    lo_x = {ccx[CW-1], ccx} - rs;
    hi_x = {ccx[CW-1], ccx} + rs;
    lo_y = {ccy[CW-1], ccy} - rs;
    hi_y = {ccy[CW-1], ccy} + rs;
    bbox1_d = !(lo_x >= $signed({bx1[CW-1], bx1}) || hi_x <= $signed({bx0[CW-1], bx0}) ||
                lo_y >= $signed({by1[CW-1], by1}) || hi_y <= $signed({by0[CW-1], by0}));

    bb_hit = !(b_v0_i >= a_v1_i || b_v1_i <= a_v0_i ||
               b_v2_i >= a_v3_i || b_v3_i <= a_v2_i);
    inbox  = (ccx >= bx0) && (ccx < bx1) && (ccy >= by0) && (ccy < by1);
    // centre between the edge ends, in either order
    proj_y = (by0 == by1) || ((ccy >= by0) && (ccy <= by1)) ||
             ((ccy <= by0) && (ccy >= by1));
    proj_x = (bx0 == bx1) || ((ccx >= bx0) && (ccx <= bx1)) ||
             ((ccx <= bx0) && (ccx >= bx1));

    unique case ({a_is_circle_i, b_is_circle_i})
      2'b00: begin
        kind1_d  = KIND_BOX_BOX;
        early1_d = bb_hit;
      end
      2'b11: begin
        kind1_d  = KIND_CIRC_CIRC;
        early1_d = 1'b0;
      end
      default: begin
        kind1_d  = KIND_BOX_CIRC;
        early1_d = bbox1_d && (inbox || proj_x || proj_y);
      end
    endcase

    if (kind1_d == KIND_CIRC_CIRC) begin
      dx0_d = {a_v0_i[CW-1], a_v0_i} - {b_v0_i[CW-1], b_v0_i};
      dy0_d = {a_v1_i[CW-1], a_v1_i} - {b_v1_i[CW-1], b_v1_i};
      dx1_d = dx0_d;
      dy1_d = dy0_d;
      rad_d = {1'b0, ra} + {1'b0, rb};
    end else begin
      dx0_d = {bx0[CW-1], bx0} - {ccx[CW-1], ccx};
      dx1_d = {bx1[CW-1], bx1} - {ccx[CW-1], ccx};
      dy0_d = {by0[CW-1], by0} - {ccy[CW-1], ccy};
      dy1_d = {by1[CW-1], by1} - {ccy[CW-1], ccy};
      rad_d = {1'b0, rc};
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic          v2_q;
  pair_kind_e    kind2_q;
  logic          early2_q, bbox2_q;
  logic [DW-1:0] mx0_q, mx1_q, my0_q, my1_q, rad2_q;

  function automatic logic [DW-1:0] abs_d(input logic signed [DW-1:0] d);
    logic [DW-1:0] u;
    u = d;
    return d[DW-1] ? (~u + 1'b1) : u;
  endfunction

  // ---------------------------------------------------------------- stage 3
  logic           v3_q;
  pair_kind_e     kind3_q;
  logic           early3_q, bbox3_q;
  logic [SQW-1:0] sx0_q, sx1_q, sy0_q, sy1_q, r2_3_q;

  // ---------------------------------------------------------------- stage 4
  logic            v4_q;
  pair_kind_e      kind4_q;
  logic            early4_q, bbox4_q;
  logic [SUMW-1:0] s00_q, s01_q, s11_q, s10_q;
  logic [SQW-1:0]  r2_4_q;

  // ---------------------------------------------------------------- stage 5
  logic done_q, hit_q;
  logic hit_d;

  always_comb begin
    logic [SUMW-1:0] r2w;
    logic            c00, c01, c11, c10;
    r2w = SUMW'(r2_4_q);
    c00 = s00_q <= r2w;
    c01 = s01_q <= r2w;
    c11 = s11_q <= r2w;
    c10 = s10_q <= r2w;
    unique case (kind4_q)
      KIND_BOX_CIRC:  hit_d = early4_q || (bbox4_q && (c00 || c01 || c11 || c10));
      KIND_CIRC_CIRC: hit_d = c00;
      default:        hit_d = early4_q;
    endcase
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i && !busy_o;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      done_q <= v4_q;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    kind1_q  <= kind1_d;
    early1_q <= early1_d;
    bbox1_q  <= bbox1_d;
    dx0_q    <= dx0_d;
    dx1_q    <= dx1_d;
    dy0_q    <= dy0_d;
    dy1_q    <= dy1_d;
    rad_q    <= rad_d;

    kind2_q  <= kind1_q;
    early2_q <= early1_q;
    bbox2_q  <= bbox1_q;
    mx0_q    <= abs_d(dx0_q);
    mx1_q    <= abs_d(dx1_q);
    my0_q    <= abs_d(dy0_q);
    my1_q    <= abs_d(dy1_q);
    rad2_q   <= rad_q;

    kind3_q  <= kind2_q;
    early3_q <= early2_q;
    bbox3_q  <= bbox2_q;
    sx0_q    <= mx0_q * mx0_q;
    sx1_q    <= mx1_q * mx1_q;
    sy0_q    <= my0_q * my0_q;
    sy1_q    <= my1_q * my1_q;
    r2_3_q   <= rad2_q * rad2_q;

    // corners: (x0,y0) (x0,y1) (x1,y1) (x1,y0)
    kind4_q  <= kind3_q;
    early4_q <= early3_q;
    bbox4_q  <= bbox3_q;
    s00_q    <= SUMW'(sx0_q) + SUMW'(sy0_q);
    s01_q    <= SUMW'(sx0_q) + SUMW'(sy1_q);
    s11_q    <= SUMW'(sx1_q) + SUMW'(sy1_q);
    s10_q    <= SUMW'(sx1_q) + SUMW'(sy0_q);
    r2_4_q   <= r2_3_q;

    hit_q    <= hit_d;
  end

  assign busy_o = 1'b0;
  assign done_o = done_q;
  assign hit_o  = hit_q;

endmodule

FILE: design/bcct_checker.sv
// ----------------------------------------------------------------------------
// bcct_checker
// Port-level checks on item timing and a few known results of the collision test.
// ----------------------------------------------------------------------------
module bcct_checker #(
  parameter int unsigned COORD_BITS = bcct_pkg::COORD_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         a_is_circle_i,
  input logic signed [COORD_BITS-1:0] a_v0_i,
  input logic signed [COORD_BITS-1:0] a_v1_i,
  input logic                         b_is_circle_i,
  input logic signed [COORD_BITS-1:0] b_v0_i,
  input logic signed [COORD_BITS-1:0] b_v1_i,
  input logic                         done_o,
  input logic                         hit_o
);

  // every accepted item gives one result on done_o
  a_item_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##5 done_o)
    else $error("accepted item gave no result");

  // no result without an item behind it
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 5))
    else $error("result with no accepted item");

  // concentric circles always collide
  a_same_centre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && a_is_circle_i && b_is_circle_i &&
    a_v0_i == b_v0_i && a_v1_i == b_v1_i |-> ##5 hit_o)
    else $error("concentric circles reported apart");

  // boxes where b starts at or right of a's right edge on x never collide
  a_box_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !a_is_circle_i && !b_is_circle_i &&
    b_v0_i >= a_v1_i |-> ##5 !hit_o)
    else $error("separated boxes reported as hit");

endmodule

bind box_circle_collision_test bcct_checker #(.COORD_BITS(COORD_BITS)) u_bcct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .a_is_circle_i (a_is_circle_i),
  .a_v0_i        (a_v0_i),
  .a_v1_i        (a_v1_i),
  .b_is_circle_i (b_is_circle_i),
  .b_v0_i        (b_v0_i),
  .b_v1_i        (b_v1_i),
  .done_o        (done_o),
  .hit_o         (hit_o)
);
